// ----- design/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define BBE_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/bbe_pkg.sv -----
// shared types and constants of the boundary extraction block
`timescale 1ns / 1ps

package bbe_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_DATA_W = 13;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam int MIN_SIZE   = 3;
    localparam int RESET_SIZE = 64;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 px;
        logic                 last;
    } result_t;

    // up to two results of one item, slot a leaves first
    typedef struct packed {
        logic    va;
        logic    vb;
        result_t a;
        result_t b;
    } res_pair_t;

endpackage

// ----- design/bbe_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bbe_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bbe_window.sv -----
// frame counters, line stores and 3x3 window with result generation
`timescale 1ns / 1ps

module bbe_window #(
    parameter int MAX_COLS = bbe_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = bbe_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  logic                           pixel_in,
    output bbe_pkg::res_pair_t             pair
);

    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ROW_OUT_W = bbe_pkg::OUT_ROW_W;
    localparam int COL_OUT_W = bbe_pkg::OUT_COL_W;
    localparam int RST_ROWS  = (MAX_ROWS < bbe_pkg::RESET_SIZE) ? MAX_ROWS : bbe_pkg::RESET_SIZE;
    localparam int RST_COLS  = (MAX_COLS < bbe_pkg::RESET_SIZE) ? MAX_COLS : bbe_pkg::RESET_SIZE;

    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [8:0]       window_reg, window_next;
    logic [1:0]       line_rd;
    logic [2:0]       new_col;
    logic [8:0]       window_cur;
    logic             interior;
    logic             border;
    bbe_pkg::result_t res_int;
    bbe_pkg::result_t res_brd;

    // register writes, sizes saturate into range
    always_comb
    begin
        logic [31:0] rows_sat;
        logic [31:0] cols_sat;
        rows_sat      = 32'(cfg_data[bbe_pkg::ROWS_CFG_W-1:0]);
        cols_sat      = 32'(cfg_data[bbe_pkg::COLS_CFG_W-1:0]);
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        if (rows_sat < 32'(bbe_pkg::MIN_SIZE))
        begin
            rows_sat = 32'(bbe_pkg::MIN_SIZE);
        end
        else if (rows_sat > 32'(MAX_ROWS))
        begin
            rows_sat = 32'(MAX_ROWS);
        end
        if (cols_sat < 32'(bbe_pkg::MIN_SIZE))
        begin
            cols_sat = 32'(bbe_pkg::MIN_SIZE);
        end
        else if (cols_sat > 32'(MAX_COLS))
        begin
            cols_sat = 32'(MAX_COLS);
        end
        if (cfg_we)
        begin
            unique case (bbe_pkg::cfg_reg_t'(cfg_index))
                bbe_pkg::REG_FRAME_ROWS: last_row_next = ROW_W'(rows_sat - 32'd1);
                bbe_pkg::REG_FRAME_COLS: last_col_next = COL_W'(cols_sat - 32'd1);
                default: ;
            endcase
        end
    end

    // newest column: bit0 two rows up, bit1 one row up, bit2 current
    assign new_col    = {pixel_in, line_rd[1], line_rd[0]};
    assign window_cur = {window_reg[5:0], new_col};

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        window_next = window_reg;
        priority if (cfg_we)
        begin
            row_next    = '0;
            col_next    = '0;
            window_next = '0;
        end
        else if (accept)
        begin
            window_next = window_cur;
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : ROW_W'(row_reg + 1'b1);
            end
            else
            begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
        else
        begin
            window_next = window_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_row_reg <= ROW_W'(RST_ROWS - 1);
            last_col_reg <= COL_W'(RST_COLS - 1);
            row_reg      <= '0;
            col_reg      <= '0;
            window_reg   <= '0;
        end
        else
        begin
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            window_reg   <= window_next;
        end
    end

    // read ahead at the column of the next item so data is ready on arrival
    bbe_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata ({pixel_in, line_rd[1]}),
        .raddr (col_next),
        .rdata (line_rd)
    );

    assign interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign border   = (row_reg == '0) || (row_reg == last_row_reg)
                   || (col_reg == '0) || (col_reg == last_col_reg);

    always_comb
    begin
        res_int.row  = ROW_OUT_W'(ROW_W'(row_reg - 1'b1));
        res_int.col  = COL_OUT_W'(COL_W'(col_reg - 1'b1));
        res_int.px   = window_cur[4] & ~(&window_cur);
        res_int.last = 1'b0;
        res_brd.row  = ROW_OUT_W'(row_reg);
        res_brd.col  = COL_OUT_W'(col_reg);
        res_brd.px   = pixel_in;
        res_brd.last = (row_reg == last_row_reg) && (col_reg == last_col_reg);
    end

    // interior result goes first when both occur
    always_comb
    begin
        pair.va = accept && (interior || border);
        pair.vb = accept && interior && border;
        pair.a  = interior ? res_int : res_brd;
        pair.b  = res_brd;
    end

endmodule

// ----- design/bbe_out_fifo.sv -----
// small result queue taking up to two results per cycle
`timescale 1ns / 1ps

module bbe_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  bbe_pkg::res_pair_t pair,
    input  logic               pop,
    output bbe_pkg::result_t   head,
    output logic               not_empty,
    output logic               room_two
);

    localparam int PTR_W = bbe_pkg::FIFO_PTR_W;
    localparam int CNT_W = bbe_pkg::FIFO_CNT_W;

    bbe_pkg::result_t mem [bbe_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       push_n;
    logic             do_pop;

    assign push_n = {1'b0, pair.va} + {1'b0, pair.vb};
    assign do_pop = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + push_n);
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push_n) - CNT_W'(do_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.va)
        begin
            mem[wr_ptr_reg] <= pair.a;
        end
        if (pair.vb)
        begin
            mem[PTR_W'(wr_ptr_reg + 1'b1)] <= pair.b;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // keep space for the two results one item may cause
    assign room_two  = (count_reg <= CNT_W'(bbe_pkg::FIFO_DEPTH - 2));

endmodule

// ----- design/binary_boundary_extraction.sv -----
// top level of the 3x3 binary boundary extraction block
// Binary pixels enter in raster order on in_valid / in_ready with pixel_in.
// Results leave on out_valid / out_ready with out_row, out_col, pixel_out
// and frame_last. A border pixel gives its own result; an interior pixel
// gives its result (pixel minus its 3x3 erosion) when its lower-right
// neighbour arrives, ahead of that neighbour's own border result.
// A result is written into the result queue as its item is accepted.
// Throughput: one item per cycle while in_ready is high; the window logic
// sits between the prefetched line store read and the result queue. Items
// that cause two results need two pops, so on the last row and column the
// rate is set by the single output port of the four entry result queue.
// cfg_we writes frame_rows (index 0) or frame_cols (index 1), saturated to
// 3..MAX_ROWS / 3..MAX_COLS, and restarts the frame at row 0, column 0.
// Reset: frame size 64 x 64, position row 0 column 0, result queue empty;
// the line store needs no clearing pass, its entries are written before use.
// When the receiver stalls, results wait in the queue and in_ready drops
// once fewer than two free entries remain.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_boundary_extraction #(
    parameter int MAX_COLS = bbe_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = bbe_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           pixel_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bbe_pkg::OUT_ROW_W-1:0]  out_row,
    output logic [bbe_pkg::OUT_COL_W-1:0]  out_col,
    output logic                           pixel_out,
    output logic                           frame_last
);

    logic               accept;
    bbe_pkg::res_pair_t pair;
    bbe_pkg::result_t   head;

    assign accept = in_valid && in_ready;

    bbe_window #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel_in  (pixel_in),
        .pair      (pair)
    );

    bbe_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair),
        .pop       (out_ready),
        .head      (head),
        .not_empty (out_valid),
        .room_two  (in_ready)
    );

    assign out_row    = head.row;
    assign out_col    = head.col;
    assign pixel_out  = head.px;
    assign frame_last = head.last;

    `BBE_ASSERT_NEVER(a_push_without_accept, (pair.va || pair.vb) && !accept, "result without item")
    `BBE_ASSERT(a_second_needs_first, pair.vb |-> pair.va, "second result slot used alone")
    `BBE_ASSERT(a_result_offered, pair.va |=> out_valid, "queued result not offered")

endmodule
